// ===== design/ukfq_pkg.sv =====
// Package for the unique-key FIFO queue: sizes, operation and status codes,
// and the structs passed between the top level and the storage cells.
// No dependencies.
`default_nettype none

package ukfq_pkg;

    // Queue depth and derived widths
    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 16;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 3;
    localparam int OUT_CNT_W = 5;

    // Operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    // Result status codes carried on m_tuser
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Search probe rippling down the cell chain
    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } probe_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic occ;    // cell holds a queued entry
        logic shift;  // take the upper neighbor's entry (pop)
        logic load;   // take the incoming entry (push)
    } cell_ctl_t;

endpackage : ukfq_pkg

`default_nettype wire

// ===== design/ukfq_cell.sv =====
// One storage cell of the queue chain: holds a single entry, shifts toward
// the head on pop, and forwards the search probe to the next cell.
// Depends on ukfq_pkg.
`default_nettype none

module ukfq_cell
    import ukfq_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [KEY_W-1:0] probe_key,   // key being searched for
    input  wire logic [KEY_W-1:0] up_key,      // entry of the cell behind
    input  wire logic [PAY_W-1:0] up_payload,
    input  wire logic [KEY_W-1:0] in_key,      // entry being pushed
    input  wire logic [PAY_W-1:0] in_payload,
    input  wire probe_t           probe_in,
    output probe_t                probe_out,
    output logic [KEY_W-1:0]      key,
    output logic [PAY_W-1:0]      payload
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] payload_reg, payload_next;
    probe_t           probe_reg, probe_next;
    logic             match;

    // Entry update: pop shift or push load
    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctl.load)
        begin
            key_next     = in_key;
            payload_next = in_payload;
        end
        else if (ctl.shift)
        begin
            key_next     = up_key;
            payload_next = up_payload;
        end
    end

    // Probe: an earlier hit passes through, otherwise this cell may hit
    assign match = ctl.occ && (key_reg == probe_key);

    always_comb
    begin
        probe_next = probe_in;
        if (!probe_in.hit && match)
        begin
            probe_next.hit     = 1'b1;
            probe_next.key     = key_reg;
            probe_next.payload = payload_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        probe_reg   <= probe_next;
    end

    assign probe_out = probe_reg;
    assign key       = key_reg;
    assign payload   = payload_reg;

endmodule : ukfq_cell

`default_nettype wire

// ===== design/unique_key_fifo_queue.sv =====
// Top level of the unique-key FIFO queue: stream handshake, sequencer,
// output register and the chain of storage cells.
// Depends on ukfq_pkg and ukfq_cell.
`default_nettype none

// A first-in first-out queue of up to DEPTH (key, payload) entries in which
// no key is queued twice. Each input beat carries an operation on s_tuser
// (insert, remove head, peek head, search by key) and gives exactly one
// result beat with a status on m_tuser and the entry, count and empty flag
// on m_tdata. Entries sit in a chain of cells, the head in the first cell;
// a pop shifts every cell one place toward the head. Remove and peek are
// answered from the head cell. Insert and search wait for the search
// probe that moves one cell per clock down the chain to check every queued
// key. One operation is in progress at a time; the next beat is accepted
// once the result register is free or being drained. The stores need no
// clearing after reset.

module unique_key_fifo_queue
    import ukfq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // key[31:0], payload[47:32]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_key[31:0], out_payload[47:32],
                                        // count[52:48], is_empty[53], zero[55:54]
    output logic [2:0]       m_tuser    // status[2:0]
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;

    logic                 m_valid_reg, m_valid_next;
    status_t              res_status_reg, res_status_next;
    logic [KEY_W-1:0]     res_key_reg, res_key_next;
    logic [PAY_W-1:0]     res_pay_reg, res_pay_next;
    logic [OUT_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 res_empty_reg, res_empty_next;
    logic                 res_load;

    logic accept;
    op_t  in_op;
    logic do_shift;
    logic do_load;

    logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;

    cell_ctl_t        ctl      [DEPTH];
    probe_t           probe    [DEPTH+1];
    logic [KEY_W-1:0] cell_key [DEPTH];
    logic [PAY_W-1:0] cell_pay [DEPTH];

    assign in_op    = op_t'(s_tuser);
    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        do_shift        = 1'b0;
        do_load         = 1'b0;
        res_load        = 1'b0;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op inside {OP_REMOVE, OP_PEEK})
                    begin
                        // head reads need no scan
                        res_load = 1'b1;
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            res_key_next    = '0;
                            res_pay_next    = '0;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            res_key_next    = cell_key[0];
                            res_pay_next    = cell_pay[0];
                            if (in_op == OP_REMOVE)
                            begin
                                do_shift   = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        op_next    = in_op;
                        key_next   = s_tdata[KEY_W-1:0];
                        pay_next   = s_tdata[KEY_W+PAY_W-1:KEY_W];
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == CNT_W'(DEPTH))
                begin
                    // probe has passed every cell
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    res_key_next = '0;
                    res_pay_next = '0;
                    if (op_reg == OP_SEARCH)
                    begin
                        if (probe[DEPTH].hit)
                        begin
                            res_status_next = ST_OK;
                            res_key_next    = probe[DEPTH].key;
                            res_pay_next    = probe[DEPTH].payload;
                        end
                        else
                        begin
                            res_status_next = ST_NOTFOUND;
                        end
                    end
                    else if (probe[DEPTH].hit)
                    begin
                        res_status_next = ST_DUP;
                    end
                    else if (count_reg == CNT_W'(DEPTH))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        res_status_next = ST_OK;
                        do_load         = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result fields reflect the count after the operation
    assign cnt_wide       = {{OUT_CNT_W{1'b0}}, count_next};
    assign res_cnt_next   = cnt_wide[OUT_CNT_W-1:0];
    assign res_empty_next = (count_next == '0);
    assign m_valid_next   = res_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        pay_reg <= pay_next;
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_key_reg    <= res_key_next;
            res_pay_reg    <= res_pay_next;
            res_cnt_reg    <= res_cnt_next;
            res_empty_reg  <= res_empty_next;
        end
    end

    // Cell chain, head in cell 0
    assign probe[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] up_key;
        logic [PAY_W-1:0] up_pay;

        if (i == DEPTH - 1)
        begin : g_last
            assign up_key = cell_key[i];
            assign up_pay = cell_pay[i];
        end
        else
        begin : g_mid
            assign up_key = cell_key[i+1];
            assign up_pay = cell_pay[i+1];
        end

        assign ctl[i].occ   = (CNT_W'(i) < count_reg);
        assign ctl[i].shift = do_shift;
        assign ctl[i].load  = do_load && (CNT_W'(i) == count_reg);

        ukfq_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl[i]),
            .probe_key  (key_reg),
            .up_key     (up_key),
            .up_payload (up_pay),
            .in_key     (key_reg),
            .in_payload (pay_reg),
            .probe_in   (probe[i]),
            .probe_out  (probe[i+1]),
            .key        (cell_key[i]),
            .payload    (cell_pay[i])
        );
    end

    // Output beat
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_status_reg;
    assign m_tdata  = {2'b00, res_empty_reg, res_cnt_reg, res_pay_reg, res_key_reg};

`ifndef SYNTH
    // Queue never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // Result register is free while a scan runs
    a_scan_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !m_valid_reg)
        else $error("result pending during scan");

    // A remove on a non-empty queue drops the count by one
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_REMOVE) && (count_reg != '0))
            |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not pop one entry");

    // A scan always ends once the scan counter reaches DEPTH
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg <= CNT_W'(DEPTH)))
        else $error("scan overran the chain");
`endif

endmodule : unique_key_fifo_queue

`default_nettype wire
